// ===== sv/dc_coefficient_chained_substitution_assert.svh =====
// Assertion macros used by the checker file of the DC coefficient cipher.
`ifndef DC_COEFFICIENT_CHAINED_SUBSTITUTION_ASSERT_SVH
`define DC_COEFFICIENT_CHAINED_SUBSTITUTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dccs_pkg.sv =====
// Shared constants and types of the DC coefficient chained substitution block.
`default_nettype none

package dccs_pkg;

  localparam int COEF_MAG_BITS = 11;
  localparam int COEF_W        = COEF_MAG_BITS + 1;
  localparam int KEY_W         = 10;
  localparam int SMEAR_STEPS   = $clog2(COEF_MAG_BITS);

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((COEF_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((COEF_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SEL_DIRECTION = 1'b0;

  // Direction register codes.
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  // Coefficient value that passes through untouched, besides zero and the most negative pattern.
  localparam logic signed [COEF_W-1:0] SKIP_COEF = -COEF_W'(1024);

  typedef logic [COEF_MAG_BITS-1:0] mag_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t            coefficient;
    logic [KEY_W-1:0] key_word;
    logic             restart;
  } item_t;

  typedef struct packed {
    logic sign;
    mag_t magnitude;
  } chain_t;

  typedef struct packed {
    coef_t result;
    logic  key_used;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/dccs_core.sv =====
// Substitution and chaining datapath for one coefficient.
`default_nettype none

module dccs_core (
  input  wire dccs_pkg::item_t   item,
  input  wire dccs_pkg::chain_t  chain,
  input  wire                    direction,
  output dccs_pkg::result_t      res,
  output dccs_pkg::chain_t       chain_nxt
);

  localparam int MB = dccs_pkg::COEF_MAG_BITS;
  localparam int CW = dccs_pkg::COEF_W;

  logic                 neg;
  logic [CW-1:0]        mag_full;
  logic                 skip;
  dccs_pkg::mag_t       mag;
  dccs_pkg::mag_t       mask;
  dccs_pkg::mag_t       msb;
  dccs_pkg::mag_t       km;
  dccs_pkg::mag_t       sum;
  dccs_pkg::mag_t       unm;
  dccs_pkg::mag_t       mag_out;
  logic                 sign_out;
  dccs_pkg::chain_t     chain_eff;

  always_comb begin
    neg      = item.coefficient[CW-1];
    mag_full = neg ? CW'(-item.coefficient) : CW'(item.coefficient);
    // The most negative pattern has no magnitude in range and passes through.
    skip     = (item.coefficient == '0) || (item.coefficient == dccs_pkg::SKIP_COEF) ||
               mag_full[CW-1];
    mag      = mag_full[MB-1:0];

    // Smear the bits below the top set bit into a mask.
    mask = mag >> 1;
    for (int i = 0; i < dccs_pkg::SMEAR_STEPS; i++) begin
      mask = mask | (mask >> (1 << i));
    end
    msb = mask + MB'(1);
    km  = MB'(item.key_word) & mask;

    chain_eff = item.restart ? '0 : chain;
    sign_out  = neg ^ item.key_word[0] ^ chain_eff.sign;

    sum = (mag + km) & mask;
    unm = (mag & mask) ^ km ^ chain_eff.magnitude;
    if (direction == dccs_pkg::DIR_DECRYPT) begin
      mag_out = ((unm - km) & mask) | msb;
    end else begin
      mag_out = ((km ^ sum ^ chain_eff.magnitude) & mask) | msb;
    end

    if (skip) begin
      res.result   = item.coefficient;
      res.key_used = 1'b0;
      chain_nxt    = chain_eff;
    end else begin
      res.result   = sign_out ? -{1'b0, mag_out} : {1'b0, mag_out};
      res.key_used = 1'b1;
      if (direction == dccs_pkg::DIR_DECRYPT) begin
        // Decryption chains on the incoming cipher value.
        chain_nxt.sign      = neg;
        chain_nxt.magnitude = mag;
      end else begin
        chain_nxt.sign      = sign_out;
        chain_nxt.magnitude = mag_out;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/dc_coefficient_chained_substitution.sv =====
// Top level of the DC coefficient chained substitution cipher.
// One coefficient and one key word enter per transfer on the in_ stream and one
// result leaves per transfer on the out_ stream. The block sustains one item
// per clock cycle while out_tready stays high. An item passes through the input
// register, then the result register, before its result is offered on out_.
// This register split follows the chain update: the sign and magnitude left by
// one item feed the next, and this add/xor path runs as an item moves from the
// input register to the result register. The input register keeps accepting
// while a finished result waits for out_tready, so one further item can be
// held before in_tready drops.
// Zero, -1024 and -2048 pass through unchanged with out_tuser low and do not
// advance the chain. in_tuser high clears the chain before its item, also for a
// pass-through value. The direction register (byte address 0, bit 0) selects
// encryption (0) or decryption (1); write it only while no item is in flight.
`default_nettype none

module dc_coefficient_chained_substitution (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Input stream.
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [dccs_pkg::IN_DATA_W-1:0]       in_tdata,   // coefficient, key_word
  input  wire                                 in_tuser,   // restart
  // Result stream.
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [dccs_pkg::OUT_DATA_W-1:0]     out_tdata,  // result
  output logic                                out_tuser,  // key_used
  // Configuration port.
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [dccs_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire [dccs_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [dccs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CW = dccs_pkg::COEF_W;
  localparam int KW = dccs_pkg::KEY_W;

  logic               direction_r, direction_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  dccs_pkg::item_t    s1_item_r, s1_item_nxt;
  logic               out_valid_r, out_valid_nxt;
  dccs_pkg::result_t  out_res_r, out_res_nxt;
  dccs_pkg::chain_t   chain_r, chain_nxt;

  dccs_pkg::result_t  core_res;
  dccs_pkg::chain_t   core_chain;

  logic out_free;
  logic s1_move;
  logic in_xfer;
  logic cfg_write;
  logic reg_sel;

  // The result register frees up when empty or when its result is taken.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[CW'(0) + dccs_pkg::CFG_ADDR_W - 1];
  assign cfg_write = psel && penable && pwrite && pready &&
                     (reg_sel == dccs_pkg::REG_SEL_DIRECTION);

  dccs_core u_core (
    .item      (s1_item_r),
    .chain     (chain_r),
    .direction (direction_r),
    .res       (core_res),
    .chain_nxt (core_chain)
  );

  always_comb begin
    direction_nxt = cfg_write ? pwdata[0] : direction_r;

    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_xfer) begin
      s1_valid_nxt            = 1'b1;
      s1_item_nxt.coefficient = in_tdata[CW-1:0];
      s1_item_nxt.key_word    = in_tdata[CW+KW-1:CW];
      s1_item_nxt.restart     = in_tuser;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    chain_nxt     = chain_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = core_res;
      chain_nxt     = core_chain;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= dccs_pkg::DIR_ENCRYPT;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r     <= '0;
    end else begin
      direction_r <= direction_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  // The bits above the result are zero fill, not a sign extension.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dccs_pkg::OUT_DATA_W - CW){1'b0}}, out_res_r.result};
  assign out_tuser  = out_res_r.key_used;

  always_comb begin
    prdata = '0;
    if (reg_sel == dccs_pkg::REG_SEL_DIRECTION) begin
      prdata[0] = direction_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dccs_checker.sv =====
// Port-level checker for the DC coefficient cipher, bound to the top level.
`default_nettype none

`include "dc_coefficient_chained_substitution_assert.svh"

module dccs_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [dccs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                             out_tuser
);

  localparam int CW = dccs_pkg::COEF_W;
  localparam logic [CW-1:0] MOST_NEG = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] SKIP_PAT = CW'(dccs_pkg::SKIP_COEF);

  // A stalled result must keep its value until it is taken.
  `DCCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A result that used no key can only be one of the pass-through values.
  `DCCS_ASSERT_NOW(a_skip_value, clk, rst_n, out_tvalid && !out_tuser, out_tdata[CW-1:0] == '0 || out_tdata[CW-1:0] == SKIP_PAT || out_tdata[CW-1:0] == MOST_NEG, "unkeyed result is not a pass-through value")

  // Substitution keeps the top magnitude bit, so a keyed result is never zero or out of range.
  `DCCS_ASSERT_NOW(a_keyed_value, clk, rst_n, out_tvalid && out_tuser, out_tdata[CW-1:0] != '0 && out_tdata[CW-1:0] != MOST_NEG, "keyed result has no valid magnitude")

  // The padding bits above the result are always zero.
  `DCCS_ASSERT_NOW(a_pad_bits, clk, rst_n, out_tvalid, out_tdata[dccs_pkg::OUT_DATA_W-1:CW] == '0, "padding bits set on a result")

endmodule

bind dc_coefficient_chained_substitution dccs_checker u_dccs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/tb_dc_coefficient_chained_substitution.sv =====
// Self-checking testbench for the DC coefficient chained substitution block.
`timescale 1ns / 1ps

module tb_dc_coefficient_chained_substitution;

  localparam int CW = dccs_pkg::COEF_W;
  localparam int MB = dccs_pkg::COEF_MAG_BITS;
  localparam int KW = dccs_pkg::KEY_W;
  localparam int AW = dccs_pkg::CFG_ADDR_W;
  localparam int DW = dccs_pkg::CFG_DATA_W;
  localparam int IW = dccs_pkg::IN_DATA_W;
  localparam int OW = dccs_pkg::OUT_DATA_W;

  // Byte address of the direction register on the configuration port.
  localparam logic [AW-1:0] ADDR_DIRECTION = AW'(4 * dccs_pkg::REG_SEL_DIRECTION);
  // The most negative 12-bit pattern has no magnitude in range and passes through.
  localparam dccs_pkg::coef_t MOST_NEG_COEF = {1'b1, {MB{1'b0}}};
  // Settling time that drain() waits once every result is back.
  localparam int DRAIN_CYCLES    = 6;
  localparam int LONG_HOLD       = 200;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RUN_ITEMS       = 120;

  // One prediction step: the result of an item and the chain it leaves behind.
  typedef struct packed {
    dccs_pkg::result_t res;
    dccs_pkg::chain_t  next;
  } cipher_step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IW-1:0]         in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OW-1:0]         out_tdata;
  logic                  out_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [AW-1:0]         paddr = '0;
  logic [DW-1:0]         pwdata = '0;
  logic [DW-1:0]         prdata;
  logic                  pready;

  // Items waiting to be offered, and results the block still owes us.
  dccs_pkg::item_t   pending_items[$];
  dccs_pkg::result_t expected_results[$];

  // Our own copy of the block's state and configuration.
  dccs_pkg::chain_t  chain_model = '0;
  logic              direction_model = dccs_pkg::DIR_ENCRYPT;

  dccs_pkg::item_t   offered_item;
  cipher_step_t      accepted_step;
  dccs_pkg::result_t due_result;
  dccs_pkg::coef_t   got_coef;

  // Idle and stall rates in percent, set between phases by the stimulus.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // The stimulus bumps hold_requests; the receiver serves each one with a long hold.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int error_count = 0;

  dc_coefficient_chained_substitution dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // coefficient, key_word
    .in_tuser  (in_tuser),   // restart
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // result
    .out_tuser (out_tuser),  // key_used
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicts one item. Zero, -1024 and the most negative pattern come back
  // unchanged, consume no key and leave the chain alone, although a restart
  // on them still clears it. Otherwise the sign is mixed with key bit 0 and
  // the chained sign, and the magnitude bits below its top set bit are mixed
  // with the key and the chained magnitude.
  function automatic cipher_step_t cipher_step(input dccs_pkg::item_t it, input logic dir,
                                               input dccs_pkg::chain_t chain_in);
    cipher_step_t     s;
    logic             neg;
    logic [CW-1:0]    abs_val;
    dccs_pkg::mag_t   mag, msb, mask, km, sum, unm, mag_out;
    logic             sign_out;
    s.next = it.restart ? dccs_pkg::chain_t'('0) : chain_in;
    if (it.coefficient == '0 || it.coefficient == dccs_pkg::SKIP_COEF ||
        it.coefficient == MOST_NEG_COEF) begin
      s.res.result = it.coefficient;
      s.res.key_used = 1'b0;
      return s;
    end
    neg = it.coefficient[CW-1];
    abs_val = neg ? (~it.coefficient + 1'b1) : it.coefficient;
    mag = abs_val[MB-1:0];
    msb = '0;
    for (int i = 0; i < MB; i++) begin
      if (mag[i]) msb = dccs_pkg::mag_t'(1) << i;
    end
    mask = msb - 1'b1;
    km = dccs_pkg::mag_t'(it.key_word) & mask;
    if (dir == dccs_pkg::DIR_ENCRYPT) begin
      sum = (mag + km) & mask;
      sign_out = it.key_word[0] ^ neg ^ s.next.sign;
      mag_out = ((km ^ sum ^ s.next.magnitude) & mask) | msb;
      s.next.sign = sign_out;
      s.next.magnitude = mag_out;
    end else begin
      // Decryption chains on the incoming cipher value, not on its own output.
      unm = (mag & mask) ^ km ^ s.next.magnitude;
      sign_out = neg ^ it.key_word[0] ^ s.next.sign;
      mag_out = ((unm - km) & mask) | msb;
      s.next.sign = neg;
      s.next.magnitude = mag;
    end
    s.res.result = dccs_pkg::coef_t'({1'b0, mag_out});
    if (sign_out) s.res.result = -s.res.result;
    s.res.key_used = 1'b1;
    return s;
  endfunction

  function automatic dccs_pkg::item_t make_item(input dccs_pkg::coef_t coef,
                                                input logic [KW-1:0] key,
                                                input logic restart);
    dccs_pkg::item_t it;
    it.coefficient = coef;
    it.key_word = key;
    it.restart = restart;
    return it;
  endfunction

  // Appends one item to the list of items still to be offered.
  task automatic add_item(input dccs_pkg::item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Random item biased toward pass-through values, small magnitudes and key extremes.
  function automatic dccs_pkg::item_t random_item();
    dccs_pkg::item_t it;
    case ($urandom_range(0, 9)) inside
      0: begin
        case ($urandom_range(0, 6))
          0: it.coefficient = '0;
          1: it.coefficient = dccs_pkg::SKIP_COEF;
          2: it.coefficient = MOST_NEG_COEF;
          3: it.coefficient = dccs_pkg::coef_t'(2047);
          4: it.coefficient = dccs_pkg::coef_t'(-2047);
          5: it.coefficient = dccs_pkg::coef_t'(1);
          default: it.coefficient = dccs_pkg::coef_t'(-1);
        endcase
      end
      [1:3]: begin
        it.coefficient = dccs_pkg::coef_t'($urandom_range(1, 15));
        if ($urandom_range(0, 1) == 1) it.coefficient = -it.coefficient;
      end
      default: it.coefficient = dccs_pkg::coef_t'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: it.key_word = '0;
      1: it.key_word = '1;
      default: it.key_word = KW'($urandom);
    endcase
    it.restart = ($urandom_range(0, 31) == 0);
    return it;
  endfunction

  // Field extremes, every pass-through value and a restart on a pass-through value.
  task automatic queue_directed();
    add_item(make_item(dccs_pkg::coef_t'(2047), 10'h3FF, 1'b1));
    add_item(make_item(dccs_pkg::coef_t'(-2047), 10'h000, 1'b0));
    add_item(make_item(dccs_pkg::coef_t'(0), 10'h155, 1'b0));
    add_item(make_item(dccs_pkg::SKIP_COEF, 10'h2AA, 1'b0));
    add_item(make_item(MOST_NEG_COEF, 10'h3FF, 1'b0));
    add_item(make_item(dccs_pkg::coef_t'(1), 10'h001, 1'b0));
    add_item(make_item(dccs_pkg::coef_t'(-1), 10'h000, 1'b0));
    add_item(make_item(dccs_pkg::coef_t'(1024), 10'h3FF, 1'b0));
    add_item(make_item(dccs_pkg::coef_t'(1023), 10'h2AA, 1'b0));
    add_item(make_item(dccs_pkg::coef_t'(-1025), 10'h155, 1'b0));
    add_item(make_item(dccs_pkg::coef_t'(0), 10'h000, 1'b1));
    add_item(make_item(dccs_pkg::coef_t'(-512), 10'h3FF, 1'b0));
  endtask

  task automatic queue_random_run(input int count);
    for (int i = 0; i < count; i++) add_item(random_item());
  endtask

  // A decryptable stream: random plaintext encrypted by a chain of our own,
  // with restart flags carried along. About one item in ten is raw noise,
  // which knocks the block's chain out of step with the sequence.
  task automatic queue_cipher_run(input int count);
    dccs_pkg::chain_t cipher_chain;
    cipher_step_t     s;
    dccs_pkg::item_t  plain;
    cipher_chain = '0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_item(random_item());
      end else begin
        plain = random_item();
        if (i == 0) plain.restart = 1'b1;
        s = cipher_step(plain, dccs_pkg::DIR_ENCRYPT, cipher_chain);
        cipher_chain = s.next;
        plain.coefficient = s.res.result;
        add_item(plain);
      end
    end
  endtask

  // Waits until every item has been offered and every result has come back.
  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the direction register, with junk in the unused bits, and reads it back.
  task automatic set_direction(input logic dir);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_DIRECTION;
    pwdata <= {(DW-1)'($urandom), dir};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    direction_model = dir;
    @(posedge clk);
    psel <= 1'b1;
    paddr <= ADDR_DIRECTION;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DW'(dir)) begin
      $error("direction readback: expected %0h, got %0h", DW'(dir), prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sender: on each input transfer the item is run through the predictor and
  // its result queued. A new item is offered when the slot is free, unless the
  // current idle rate says to leave a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accepted_step = cipher_step(offered_item, direction_model, chain_model);
        chain_model = accepted_step.next;
        expected_results.insert(expected_results.size(), accepted_step.res);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IW'({offered_item.key_word, offered_item.coefficient});
          in_tuser <= offered_item.restart;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result transfer against the oldest prediction. It
  // stalls at the current rate, and serves a long-hold request by keeping
  // out_tready low for a long stretch while the sender keeps pushing.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_coef = dccs_pkg::coef_t'(out_tdata[CW-1:0]);
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: result %0d, key_used %0b", got_coef, out_tuser);
          error_count++;
        end else begin
          due_result = expected_results.pop_front();
          if (got_coef !== due_result.result) begin
            $error("result: expected %0d, got %0d", $signed(due_result.result), got_coef);
            error_count++;
          end
          if (out_tuser !== due_result.key_used) begin
            $error("key_used: expected %0b, got %0b", due_result.key_used, out_tuser);
            error_count++;
          end
          if (out_tdata[OW-1:CW] !== '0) begin
            $error("tdata padding: expected 0, got %0h", out_tdata[OW-1:CW]);
            error_count++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: too many cycles without any transfer means the block is stuck.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_dc_coefficient_chained_substitution NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int   phase;
    logic dir;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items, first encrypted, then decrypted, with no idling.
    set_direction(dccs_pkg::DIR_ENCRYPT);
    queue_directed();
    drain();
    set_direction(dccs_pkg::DIR_DECRYPT);
    queue_directed();
    drain();

    // Random runs: each idling mode is visited once per direction.
    for (phase = 0; phase < 8; phase++) begin
      dir = phase[0] ? dccs_pkg::DIR_DECRYPT : dccs_pkg::DIR_ENCRYPT;
      set_direction(dir);
      case (phase / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (dir == dccs_pkg::DIR_DECRYPT) queue_cipher_run(RUN_ITEMS);
      else queue_random_run(RUN_ITEMS);
      drain();
    end

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering, so the block fills and drops in_tready.
    set_direction(dccs_pkg::DIR_ENCRYPT);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    queue_random_run(130);
    drain();

    // The sender pauses mid-stream until every result is back, then resumes.
    set_direction(dccs_pkg::DIR_DECRYPT);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    queue_cipher_run(60);
    drain();
    queue_cipher_run(60);
    drain();

    if (error_count == 0) begin
      $display("tb_dc_coefficient_chained_substitution OK");
    end else begin
      $display("tb_dc_coefficient_chained_substitution NOT OK");
    end
    $finish;
  end

endmodule
